// ----- hdl/spm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spm_pkg
// shared widths, constants and controller/datapath interface types for the
// sparse polynomial multiplier
// ----------------------------------------------------------------------------
package spm_pkg;

  localparam int COEF_W    = 16;
  localparam int EXP_W     = 5;
  localparam int SLOT_W    = 6;
  localparam int PROD_W    = 2 * COEF_W;
  localparam int SUM_W     = 44;
  localparam int EXP_SLOTS = 63;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(EXP_SLOTS - 1);

  // commands from the controller to the datapath
  typedef struct packed {
    logic store_a;     // write the incoming term into the first-polynomial store
    logic load_b;      // capture a second-polynomial term, rewind the term index
    logic mac_issue;   // read one stored term and launch its product
    logic scan_rd;     // read the accumulator at the scan slot
    logic scan_next;   // advance the scan slot
    logic out_load;    // load the output register from the accumulator read
    logic clear_all;   // drop stored terms and present marks
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic count_zero;    // no first-polynomial terms stored
    logic idx_last;      // term index is at the last stored term
    logic pipe_busy;     // products still in flight
    logic slot_present;  // scan slot holds a present exponent
    logic slot_end;      // scan slot is the highest exponent
    logic out_last;      // output register holds the final result
  } status_t;

endpackage

// ----- hdl/sparse_polynomial_multiply.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_polynomial_multiply
// product of two sparse polynomials streamed in as coefficient/exponent terms
// ----------------------------------------------------------------------------
// terms of the first polynomial (poly_select = 0) are stored, up to MAX_TERMS
// of them, one beat per cycle; further ones are dropped. each term of the
// second polynomial (poly_select = 1) is multiplied against every stored term,
// one product per cycle through a three-stage multiply-accumulate pipeline
// (term store read, 16x16 multiply, accumulator read-modify-write).
// the second-polynomial beat flagged last_term starts the result scan: the 63
// exponent slots are walked one per cycle, pausing at each slot that received
// any product, zero sums too, which goes out as one result beat in ascending
// exponent order, held under output backpressure; last_result marks the final
// one. after the scan the block returns to its empty state and takes new
// terms. input is not taken while a product pass or the scan is running.
// accumulators wrap at 44 bits.
module sparse_polynomial_multiply
  import spm_pkg::*;
#(
  parameter int MAX_TERMS = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     poly_select,
  input  logic signed [COEF_W-1:0] coefficient,
  input  logic [EXP_W-1:0]         exponent,
  input  logic                     last_term,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [SUM_W-1:0]  product_coefficient,
  output logic [SLOT_W-1:0]        product_exponent,
  output logic                     last_result
);

  cmd_t    cmd;
  status_t status;

  // sequencer: idle / product pass / drain / scan / load / send
  spm_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .poly_select (poly_select),
    .last_term   (last_term),
    .out_ready   (out_ready),
    .status      (status),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .cmd         (cmd)
  );

  // storage, products, accumulators and the output register
  spm_dp #(
    .MAX_TERMS (MAX_TERMS)
  ) u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .coefficient         (coefficient),
    .exponent            (exponent),
    .status              (status),
    .product_coefficient (product_coefficient),
    .product_exponent    (product_exponent),
    .last_result         (last_result)
  );

endmodule

// ----- hdl/spm_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spm_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module spm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/spm_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spm_ctrl
// sequencer for term storage, multiply-accumulate passes and result scan
// ----------------------------------------------------------------------------
module spm_ctrl
  import spm_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    poly_select,
  input  logic    last_term,
  input  logic    out_ready,
  input  status_t status,
  output logic    in_ready,
  output logic    out_valid,
  output cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MAC   = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_LOAD  = 3'd4;
  localparam logic [2:0] ST_SEND  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       b_last;
  logic       b_last_next;
  logic       in_beat;

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_SEND);
  assign in_beat   = in_valid && in_ready;

  always_comb begin
    state_next  = state;
    b_last_next = b_last;
    cmd         = '0;
    case (state)
      ST_IDLE: begin
        if (in_beat) begin
          if (!poly_select) begin
            cmd.store_a = 1'b1;
          end else begin
            cmd.load_b  = 1'b1;
            b_last_next = last_term;
            if (!status.count_zero) begin
              state_next = ST_MAC;
            end else if (last_term) begin
              state_next = ST_SCAN;
            end
          end
        end
      end
      ST_MAC: begin
        cmd.mac_issue = 1'b1;
        if (status.idx_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) begin
          state_next = b_last ? ST_SCAN : ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (status.slot_present) begin
          cmd.scan_rd = 1'b1;
          state_next  = ST_LOAD;
        end else if (status.slot_end) begin
          cmd.clear_all = 1'b1;
          state_next    = ST_IDLE;
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      ST_LOAD: begin
        cmd.out_load = 1'b1;
        state_next   = ST_SEND;
      end
      ST_SEND: begin
        if (out_ready) begin
          if (status.out_last) begin
            cmd.clear_all = 1'b1;
            state_next    = ST_IDLE;
          end else begin
            cmd.scan_next = 1'b1;
            state_next    = ST_SCAN;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      b_last <= 1'b0;
    end else begin
      state  <= state_next;
      b_last <= b_last_next;
    end
  end

endmodule

// ----- hdl/spm_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spm_dp
// term store, multiply-accumulate pipeline, accumulator ram and output register
// ----------------------------------------------------------------------------
module spm_dp
  import spm_pkg::*;
#(
  parameter int MAX_TERMS = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cmd_t                     cmd,
  input  logic signed [COEF_W-1:0] coefficient,
  input  logic [EXP_W-1:0]         exponent,
  output status_t                  status,
  output logic signed [SUM_W-1:0]  product_coefficient,
  output logic [SLOT_W-1:0]        product_exponent,
  output logic                     last_result
);

  localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CW = $clog2(MAX_TERMS + 1);
  localparam int TW = COEF_W + EXP_W;

  // term store and index
  logic [CW-1:0]            count;
  logic [AW-1:0]            idx;
  logic                     a_we;
  logic [TW-1:0]            a_rdata;
  logic signed [COEF_W-1:0] a_coef;
  logic [EXP_W-1:0]         a_exp;

  // captured second-polynomial term
  logic signed [COEF_W-1:0] b_coef;
  logic [EXP_W-1:0]         b_exp;

  // pipeline
  logic                     rv;
  logic                     pv;
  logic signed [PROD_W-1:0] p_prod;
  logic [SLOT_W-1:0]        p_e;
  logic [SLOT_W-1:0]        e_sum;
  logic                     fwd_v;
  logic [SLOT_W-1:0]        fwd_e;
  logic [SUM_W-1:0]         fwd_val;
  logic [SUM_W-1:0]         base;
  logic [SUM_W-1:0]         acc_sum;

  // accumulator and scan
  logic [EXP_SLOTS-1:0]     present;
  logic [SLOT_W-1:0]        scan;
  logic [SLOT_W-1:0]        acc_raddr;
  logic [SUM_W-1:0]         acc_rdata;
  logic [EXP_SLOTS-1:0]     above;

  assign a_we = cmd.store_a && (count < CW'(MAX_TERMS));

  spm_ram #(
    .WIDTH (TW),
    .DEPTH (MAX_TERMS)
  ) u_terms (
    .clk   (clk),
    .we    (a_we),
    .waddr (count[AW-1:0]),
    .wdata ({coefficient, exponent}),
    .raddr (idx),
    .rdata (a_rdata)
  );

  assign a_coef = a_rdata[TW-1:EXP_W];
  assign a_exp  = a_rdata[EXP_W-1:0];
  assign e_sum  = {1'b0, a_exp} + {1'b0, b_exp};

  // a same-slot write from the previous product is not yet visible in the ram read
  always_comb begin
    if (fwd_v && (fwd_e == p_e)) begin
      base = fwd_val;
    end else if (present[p_e]) begin
      base = acc_rdata;
    end else begin
      base = '0;
    end
  end

  assign acc_sum   = base + {{(SUM_W - PROD_W){p_prod[PROD_W-1]}}, p_prod};
  assign acc_raddr = cmd.scan_rd ? scan : e_sum;

  spm_ram #(
    .WIDTH (SUM_W),
    .DEPTH (EXP_SLOTS)
  ) u_acc (
    .clk   (clk),
    .we    (pv),
    .waddr (p_e),
    .wdata (acc_sum),
    .raddr (acc_raddr),
    .rdata (acc_rdata)
  );

  always_comb begin
    for (int j = 0; j < EXP_SLOTS; j++) begin
      above[j] = present[j] && (SLOT_W'(j) > scan);
    end
  end

  assign status.count_zero   = (count == '0);
  assign status.idx_last     = ((CW'(idx) + CW'(1)) == count);
  assign status.pipe_busy    = rv || pv;
  assign status.slot_present = present[scan];
  assign status.slot_end     = (scan == LAST_SLOT);
  assign status.out_last     = last_result;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      idx     <= '0;
      rv      <= 1'b0;
      pv      <= 1'b0;
      fwd_v   <= 1'b0;
      present <= '0;
      scan    <= '0;
    end else begin
      rv    <= cmd.mac_issue;
      pv    <= rv;
      fwd_v <= pv;
      if (a_we) begin
        count <= count + CW'(1);
      end
      if (cmd.load_b) begin
        idx <= '0;
      end else if (cmd.mac_issue) begin
        idx <= idx + AW'(1);
      end
      if (pv) begin
        present[p_e] <= 1'b1;
      end
      if (cmd.scan_next) begin
        scan <= scan + SLOT_W'(1);
      end
      if (cmd.clear_all) begin
        count   <= '0;
        present <= '0;
        scan    <= '0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_b) begin
      b_coef <= coefficient;
      b_exp  <= exponent;
    end
    if (rv) begin
      p_prod <= PROD_W'(a_coef) * PROD_W'(b_coef);
      p_e    <= e_sum;
    end
    if (pv) begin
      fwd_e   <= p_e;
      fwd_val <= acc_sum;
    end
    if (cmd.out_load) begin
      product_coefficient <= acc_rdata;
      product_exponent    <= scan;
      last_result         <= ~|above;
    end
  end

endmodule

// ----- hdl/spm_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spm_check
// port-level checks for the sparse polynomial multiplier, bound to the top
// ----------------------------------------------------------------------------
module spm_check
  import spm_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     poly_select,
  input logic signed [COEF_W-1:0] coefficient,
  input logic [EXP_W-1:0]         exponent,
  input logic                     last_term,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [SUM_W-1:0]  product_coefficient,
  input logic [SLOT_W-1:0]        product_exponent,
  input logic                     last_result
);

  // results only go out while input is held off
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while a result is pending");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(product_coefficient)
      && $stable(product_exponent) && $stable(last_result))
    else $error("result beat changed while stalled");

  // the final result returns the block to taking terms
  a_done_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last_result |=> in_ready)
    else $error("not ready after final result");

  // more results follow a non-final one, input stays held off
  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_result |=> !in_ready && !out_valid)
    else $error("scan ended early after a non-final result");

  // a second-polynomial last term is never followed directly by ready
  a_last_b_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && poly_select && last_term |=> !in_ready)
    else $error("ready right after the last term");

endmodule

bind sparse_polynomial_multiply spm_check u_check (.*);
